@@ hw/rtl/mid_pkg.sv @@
// Package for the modular inverse divider: word widths, request and result
// types, register index and sequencer state type.
// No dependencies.
package mid_pkg;

	localparam int WORD_WIDTH = 16;
	localparam int T_WIDTH = WORD_WIDTH + 2;
	localparam int CNT_WIDTH = $clog2(WORD_WIDTH);
	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;

	localparam logic [WORD_WIDTH-1:0] MODULUS_RESET = WORD_WIDTH'(23);
	localparam logic REG_MODULUS = 1'b0;

	typedef struct packed {
		logic [WORD_WIDTH-1:0]        dividend;
		logic signed [WORD_WIDTH-1:0] divisor;
	} in_item_t;

	typedef struct packed {
		logic [WORD_WIDTH-1:0] inverse;
		logic [WORD_WIDTH-1:0] quotient;
		logic                  no_inverse;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REDUCE,
		S_FIXSIGN,
		S_EUC_DIV,
		S_EUC_UPD,
		S_INVFIX,
		S_MUL_DBL,
		S_MUL_ADD,
		S_FINISH
	} state_t;

endpackage

@@ hw/rtl/mid_modadd.sv @@
// Shared arithmetic unit: adds two residues and a carry, then subtracts d (the
// modulus or the Euclid divisor) once when the sum reaches it, for division and modular steps.
// Depends on mid_pkg.
module mid_modadd
	import mid_pkg::*;
(
	input  logic [WORD_WIDTH-1:0] a,
	input  logic [WORD_WIDTH-1:0] b,
	input  logic                  cin,
	input  logic [WORD_WIDTH-1:0] d,
	output logic [WORD_WIDTH-1:0] sum,
	output logic                  ge
);

	logic [WORD_WIDTH:0] wide;
	logic [WORD_WIDTH:0] diff;

	always_comb begin
		wide = {1'b0, a} + {1'b0, b} + (WORD_WIDTH + 1)'(cin);
		diff = wide - {1'b0, d};
		ge   = (wide >= {1'b0, d});
		sum  = ge ? diff[WORD_WIDTH-1:0] : wide[WORD_WIDTH-1:0];
	end

endmodule

@@ hw/rtl/modular_inverse_divider.sv @@
// Modular inverse divider: one request in flight, results via an output register.
// All arithmetic runs through the single shared add-and-reduce unit, taking one bit a cycle
// in the reduction and Euclid divisions. A divisor with no residue or a modulus below two ends
// with no_inverse set before any Euclid step, and one sharing a factor with the modulus, before the multiply.
// A new request is taken only once the previous result is in the output register and the block is idle.
// Reset sets the modulus to 23 and empties the block.
module modular_inverse_divider
	import mid_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_item_t                  in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_item_t                 out_data,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	typedef struct packed {
		logic [WORD_WIDTH-1:0] a;
		logic [WORD_WIDTH-1:0] b;
		logic                  cin;
		logic [WORD_WIDTH-1:0] d;
	} unit_op_t;

	state_t state_q, state_d;

	logic [WORD_WIDTH-1:0]      modulus_q;
	logic                       out_valid_q;
	out_item_t                  out_data_q;

	logic [WORD_WIDTH-1:0]      dividend_q;
	logic [WORD_WIDTH-1:0]      num_q;
	logic                       neg_q;
	logic [WORD_WIDTH-1:0]      rem_q;
	logic [WORD_WIDTH-1:0]      r_prev_q;
	logic [WORD_WIDTH-1:0]      r_cur_q;
	logic signed [T_WIDTH-1:0]  t_prev_q;
	logic signed [T_WIDTH-1:0]  t_cur_q;
	logic signed [T_WIDTH-1:0]  tacc_q;
	logic [WORD_WIDTH-1:0]      inv_q;
	logic [CNT_WIDTH-1:0]       cnt_q;
	logic                       fail_q;

	unit_op_t                   op;
	logic [WORD_WIDTH-1:0]      unit_sum;
	logic                       unit_ge;
	logic                       cfg_write;
	logic                       in_accept;
	logic                       out_load;
	logic                       cnt_last;
	logic                       modulus_small;
	logic [WORD_WIDTH-1:0]      div_raw;
	logic [WORD_WIDTH-1:0]      div_mag;
	logic signed [T_WIDTH-1:0]  inv_wide;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign prdata    = (paddr[2] == REG_MODULUS) ?
		APB_DATA_WIDTH'(modulus_q) : '0;

	assign in_accept     = in_valid & ~in_stall;
	assign cnt_last      = (cnt_q == '0);
	assign modulus_small = (modulus_q < WORD_WIDTH'(2));
	assign div_raw       = in_data.divisor;
	assign div_mag       = div_raw[WORD_WIDTH-1] ? (~div_raw + 1'b1) : div_raw;
	assign inv_wide      = t_prev_q[T_WIDTH-1] ?
		(t_prev_q + $signed({2'b00, modulus_q})) : t_prev_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	mid_modadd u_modadd (
		.a   (op.a),
		.b   (op.b),
		.cin (op.cin),
		.d   (op.d),
		.sum (unit_sum),
		.ge  (unit_ge)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = modulus_small ? S_FINISH : S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (cnt_last) begin
					state_d = S_FIXSIGN;
				end
			end
			S_FIXSIGN: begin
				state_d = (rem_q == '0) ? S_FINISH : S_EUC_DIV;
			end
			S_EUC_DIV: begin
				if (cnt_last) begin
					state_d = S_EUC_UPD;
				end
			end
			S_EUC_UPD: begin
				state_d = (rem_q == '0) ? S_INVFIX : S_EUC_DIV;
			end
			S_INVFIX: begin
				state_d = (r_prev_q == WORD_WIDTH'(1)) ? S_MUL_DBL : S_FINISH;
			end
			S_MUL_DBL: begin
				state_d = S_MUL_ADD;
			end
			S_MUL_ADD: begin
				if (cnt_last) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_MUL_DBL;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		op       = '0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_REDUCE: begin
				op = '{a: rem_q, b: rem_q, cin: num_q[WORD_WIDTH-1], d: modulus_q};
			end
			S_EUC_DIV: begin
				op = '{a: rem_q, b: rem_q, cin: num_q[WORD_WIDTH-1], d: r_cur_q};
			end
			S_MUL_DBL: begin
				op = '{a: rem_q, b: rem_q, cin: 1'b0, d: modulus_q};
			end
			S_MUL_ADD: begin
				op = '{a: rem_q, b: (dividend_q[WORD_WIDTH-1] ? inv_q : '0),
					cin: 1'b0, d: modulus_q};
			end
			S_FINISH: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			modulus_q   <= MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && paddr[2] == REG_MODULUS) begin
				modulus_q <= pwdata[WORD_WIDTH-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					dividend_q <= in_data.dividend;
					neg_q      <= div_raw[WORD_WIDTH-1];
					num_q      <= div_mag;
					rem_q      <= '0;
					cnt_q      <= CNT_WIDTH'(WORD_WIDTH - 1);
					fail_q     <= modulus_small;
				end
			end
			S_REDUCE: begin
				rem_q <= unit_sum;
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			S_FIXSIGN: begin
				r_prev_q <= modulus_q;
				r_cur_q  <= (neg_q && rem_q != '0) ? (modulus_q - rem_q) : rem_q;
				t_prev_q <= '0;
				t_cur_q  <= T_WIDTH'(1);
				tacc_q   <= '0;
				num_q    <= modulus_q;
				rem_q    <= '0;
				cnt_q    <= CNT_WIDTH'(WORD_WIDTH - 1);
				if (rem_q == '0) begin
					fail_q <= 1'b1;
				end
			end
			S_EUC_DIV: begin
				rem_q  <= unit_sum;
				num_q  <= num_q << 1;
				tacc_q <= (tacc_q <<< 1) + (unit_ge ? t_cur_q : T_WIDTH'(0));
				cnt_q  <= cnt_q - 1'b1;
			end
			S_EUC_UPD: begin
				r_prev_q <= r_cur_q;
				r_cur_q  <= rem_q;
				t_prev_q <= t_cur_q;
				t_cur_q  <= t_prev_q - tacc_q;
				tacc_q   <= '0;
				num_q    <= r_cur_q;
				rem_q    <= '0;
				cnt_q    <= CNT_WIDTH'(WORD_WIDTH - 1);
			end
			S_INVFIX: begin
				inv_q <= inv_wide[WORD_WIDTH-1:0];
				rem_q <= '0;
				cnt_q <= CNT_WIDTH'(WORD_WIDTH - 1);
				if (r_prev_q != WORD_WIDTH'(1)) begin
					fail_q <= 1'b1;
				end
			end
			S_MUL_DBL: begin
				rem_q <= unit_sum;
			end
			S_MUL_ADD: begin
				rem_q      <= unit_sum;
				dividend_q <= dividend_q << 1;
				cnt_q      <= cnt_q - 1'b1;
			end
			S_FINISH: begin
				if (out_load) begin
					if (fail_q) begin
						out_data_q <= '{inverse: '0, quotient: '0, no_inverse: 1'b1};
					end else begin
						out_data_q <= '{inverse: inv_q, quotient: rem_q, no_inverse: 1'b0};
					end
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule
